// File: rtl/periodic_task_timer_table_defines.svh
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PTTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PTTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pttt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pttt_pkg;

    localparam int TIME_W = 32;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 6;
    localparam int SLOT_IN_W = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD_REP = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_ONE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RUN     = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ACK   = 3'd0;
    localparam logic [STAT_W-1:0] ST_ADDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FIRED = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE  = 3'd4;

    // write side of the time store
    typedef struct packed {
        logic              per_we;
        logic              due_we;
        logic [TIME_W-1:0] per_d;
        logic [TIME_W-1:0] due_d;
    } t_store_wr;

    // registered read data of the time store
    typedef struct packed {
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] due;
    } t_store_rd;

endpackage

`default_nettype wire

// File: rtl/pttt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module pttt_store #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  wire                      i_clk,
    input  wire [IW-1:0]             i_waddr,
    input  wire pttt_pkg::t_store_wr i_wr,
    input  wire                      i_rd_en,
    input  wire [IW-1:0]             i_raddr,
    output pttt_pkg::t_store_rd      o_rd
);
    import pttt_pkg::*;

    logic [TIME_W-1:0] mem_per [DEPTH];
    logic [TIME_W-1:0] mem_due [DEPTH];
    logic [TIME_W-1:0] r_rd_per;
    logic [TIME_W-1:0] r_rd_due;

    // period memory: written on add only
    always_ff @(posedge i_clk) begin
        if (i_wr.per_we) begin
            mem_per[i_waddr] <= i_wr.per_d;
        end
        if (i_rd_en) begin
            r_rd_per <= mem_per[i_raddr];
        end
    end

    // due-time memory: written on add and on a repeating fire
    always_ff @(posedge i_clk) begin
        if (i_wr.due_we) begin
            mem_due[i_waddr] <= i_wr.due_d;
        end
        if (i_rd_en) begin
            r_rd_due <= mem_due[i_raddr];
        end
    end

    assign o_rd = {r_rd_per, r_rd_due};

endmodule

`default_nettype wire

// File: rtl/periodic_task_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_timer_table_defines.svh"

// Periodic task timer table.
// Requests enter on start/busy: a request is taken at a clock edge where start
// is high and busy is low. Each result shows on o_status/o_slot_out/o_last for
// one cycle with o_valid high; o_last marks the final result of a request.
// The receiver cannot stall, so results are never held back.
// Remove, enable, disable and unused codes: acknowledged in the next cycle,
// busy stays low, so one such request per cycle is taken.
// Add: one slot a cycle is tested for a free entry, and the result comes
// once a free slot is claimed or the last slot is found taken (full).
// Run: the time store is read one slot a cycle through registered read data,
// and busy stays high until every slot has been evaluated; each fire result
// is held until the next fire or the flush cycle, so the final result of a
// run is the one given out by the flush state.
// Reset clears all slot marks; the period and due-time memories are not
// cleared, as an entry's times are only used once an add has written them.
module periodic_task_timer_table #(
    parameter int MAX_TASKS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  [pttt_pkg::REQ_W-1:0]      i_req_type,
    input  wire  [pttt_pkg::SLOT_IN_W-1:0]  i_slot,
    input  wire  [pttt_pkg::TIME_W-1:0]     i_period,
    input  wire  [pttt_pkg::TIME_W-1:0]     i_now,
    output logic                            o_valid,
    output logic [pttt_pkg::STAT_W-1:0]     o_status,
    output logic [pttt_pkg::SLOT_W-1:0]     o_slot_out,
    output logic                            o_last
);
    import pttt_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADD   = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    // control state
    logic [1:0]           r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_rd_on, n_rd_on;
    logic                 r_s2_valid, n_s2_valid;
    logic [IW-1:0]        r_s2_idx, n_s2_idx;
    logic                 r_pend_valid, n_pend_valid;
    logic [IW-1:0]        r_pend_idx, n_pend_idx;
    logic [MAX_TASKS-1:0] r_occ, n_occ;
    logic [MAX_TASKS-1:0] r_ena, n_ena;
    logic [MAX_TASKS-1:0] r_rep, n_rep;
    logic                 r_valid, n_valid;

    // request payload and result payload
    logic                 r_rep_req;
    logic [TIME_W-1:0]    r_period;
    logic [TIME_W-1:0]    r_now;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [SLOT_W-1:0]    r_slot_out, n_slot_out;
    logic                 r_last, n_last;

    // store access
    t_store_wr            st_wr;
    t_store_rd            st_rd;
    logic [IW-1:0]        st_waddr;
    logic                 st_rd_en;

    logic                 accept;
    logic                 in_range;
    logic [IW-1:0]        sidx;
    logic [TIME_W-1:0]    lag;
    logic                 fire;

    assign accept   = start && (r_state == S_IDLE);
    assign in_range = i_slot < SLOT_IN_W'(MAX_TASKS);
    assign sidx     = i_slot[IW-1:0];
    assign lag      = r_now - st_rd.due;
    assign fire     = r_s2_valid && r_occ[r_s2_idx] && r_ena[r_s2_idx] && !lag[TIME_W-1];

    // sequencer and slot marks
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rd_on      = r_rd_on;
        n_s2_valid   = 1'b0;
        n_s2_idx     = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_occ        = r_occ;
        n_ena        = r_ena;
        n_rep        = r_rep;
        n_valid      = 1'b0;
        n_status     = ST_ACK;
        n_slot_out   = '0;
        n_last       = 1'b1;
        st_wr        = '0;
        st_waddr     = r_idx;
        st_rd_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        REQ_ADD_REP, REQ_ADD_ONE: begin
                            n_state = S_ADD;
                            n_idx   = '0;
                        end
                        REQ_REMOVE: begin
                            if (in_range) begin
                                n_occ[sidx] = 1'b0;
                                n_ena[sidx] = 1'b0;
                            end
                            n_valid = 1'b1;
                        end
                        REQ_ENABLE: begin
                            if (in_range && r_occ[sidx]) begin
                                n_ena[sidx] = 1'b1;
                            end
                            n_valid = 1'b1;
                        end
                        REQ_DISABLE: begin
                            if (in_range) begin
                                n_ena[sidx] = 1'b0;
                            end
                            n_valid = 1'b1;
                        end
                        REQ_RUN: begin
                            n_state      = S_RUN;
                            n_idx        = '0;
                            n_rd_on      = 1'b1;
                            n_pend_valid = 1'b0;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD: begin
                // one slot tested a cycle for a free entry
                if (!r_occ[r_idx]) begin
                    n_occ[r_idx] = 1'b1;
                    n_ena[r_idx] = 1'b1;
                    n_rep[r_idx] = r_rep_req;
                    st_wr.per_we = 1'b1;
                    st_wr.due_we = 1'b1;
                    st_wr.per_d  = r_period;
                    st_wr.due_d  = r_now + r_period;
                    n_valid      = 1'b1;
                    n_status     = ST_ADDED;
                    n_slot_out   = SLOT_W'(r_idx);
                    n_state      = S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    n_valid = 1'b1;
                    n_status = ST_FULL;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RUN: begin
                // read issue for the next slot
                if (r_rd_on) begin
                    st_rd_en   = 1'b1;
                    n_s2_valid = 1'b1;
                    n_s2_idx   = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // evaluate the slot whose times just came back
                if (fire) begin
                    if (r_rep[r_s2_idx]) begin
                        st_wr.due_we = 1'b1;
                        st_wr.due_d  = st_rd.due + st_rd.per;
                        st_waddr     = r_s2_idx;
                    end else begin
                        n_ena[r_s2_idx] = 1'b0;
                    end
                    // a held fire is released now that another follows
                    if (r_pend_valid) begin
                        n_valid    = 1'b1;
                        n_status   = ST_FIRED;
                        n_slot_out = SLOT_W'(r_pend_idx);
                        n_last     = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_idx   = r_s2_idx;
                end
                if (r_s2_valid && (r_s2_idx == LAST_IDX)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                if (r_pend_valid) begin
                    n_status   = ST_FIRED;
                    n_slot_out = SLOT_W'(r_pend_idx);
                end else begin
                    n_status = ST_NONE;
                end
                n_pend_valid = 1'b0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_rd_on      <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_occ        <= '0;
            r_ena        <= '0;
            r_rep        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rd_on      <= n_rd_on;
            r_s2_valid   <= n_s2_valid;
            r_pend_valid <= n_pend_valid;
            r_occ        <= n_occ;
            r_ena        <= n_ena;
            r_rep        <= n_rep;
            r_valid      <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rep_req <= (i_req_type == REQ_ADD_REP);
            r_period  <= i_period;
            r_now     <= i_now;
        end
        r_s2_idx   <= n_s2_idx;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_last     <= n_last;
    end

    pttt_store #(
        .DEPTH (MAX_TASKS),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_waddr (st_waddr),
        .i_wr    (st_wr),
        .i_rd_en (st_rd_en),
        .i_raddr (r_idx),
        .o_rd    (st_rd)
    );

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_slot_out = r_slot_out;
    assign o_last     = r_last;

    // checks
    `PTTT_ASSERT_NEXT(a_req_answered, start && !busy, busy || o_valid, "request not answered")
    `PTTT_ASSERT_NEXT(a_flush_last, r_state == S_FLUSH, o_valid && o_last, "no final result")
    `PTTT_ASSERT_NOW(a_single_last, o_valid && (o_status != ST_FIRED), o_last, "unmarked result")
    `PTTT_ASSERT_NOW(a_s2_in_run, r_s2_valid, r_state == S_RUN, "slot evaluated outside a run")
    `PTTT_ASSERT_NOW(a_no_wr_clash, st_wr.due_we && st_rd_en, st_waddr != r_idx, "due write clash")

endmodule

`default_nettype wire

// File: tb/sv/periodic_task_timer_table_tb.sv
`timescale 1ns / 1ps

module periodic_task_timer_table_tb;
    import pttt_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int RANDOM_PER_PHASE = 141;
    localparam int MAX_GAP = 40;

    // request codes the block does not decode
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_timer_result;

    // one stimulus row; typed marks a row whose single result is written out
    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic [SLOT_IN_W-1:0] slot;
        logic [TIME_W-1:0]    period;
        logic [TIME_W-1:0]    now;
        logic                 typed;
        logic [STAT_W-1:0]    st;
        logic [SLOT_W-1:0]    sl;
        logic [4:0]           reps;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type = '0;
    logic [SLOT_IN_W-1:0]  i_slot = '0;
    logic [TIME_W-1:0]     i_period = '0;
    logic [TIME_W-1:0]     i_now = '0;
    logic                  o_valid;
    logic [STAT_W-1:0]     o_status;
    logic [SLOT_W-1:0]     o_slot_out;
    logic                  o_last;

    // written-out expectation travelling alongside the request
    logic                  row_typed = 1'b0;
    t_timer_result         row_expect = '0;

    // shadow of the slot table
    logic                  slot_occ [NUM_SLOTS];
    logic                  slot_en  [NUM_SLOTS];
    logic                  slot_rep [NUM_SLOTS];
    logic [TIME_W-1:0]     slot_per [NUM_SLOTS];
    logic [TIME_W-1:0]     slot_due [NUM_SLOTS];

    t_timer_result         step_results [$];
    t_timer_result         timer_results_q [$];
    int                    fail_count = 0;
    int                    idle_pct = 0;
    logic [TIME_W-1:0]     tick_now = '0;

    periodic_task_timer_table #(
        .MAX_TASKS(NUM_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_slot     (i_slot),
        .i_period   (i_period),
        .i_now      (i_now),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_slot_out (o_slot_out),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_occ[i] = 1'b0;
            slot_en[i]  = 1'b0;
            slot_rep[i] = 1'b0;
            slot_per[i] = '0;
            slot_due[i] = '0;
        end
    end

    function automatic t_timer_result make_result(input logic [STAT_W-1:0] st,
                                                  input int sl, input logic last);
        t_timer_result r;
        r.status = st;
        r.slot   = sl[SLOT_W-1:0];
        r.last   = last;
        return r;
    endfunction

    // apply one request to the shadow table; results land in step_results
    task automatic predict_request(input logic [REQ_W-1:0] req,
                                   input logic [SLOT_IN_W-1:0] slot,
                                   input logic [TIME_W-1:0] per,
                                   input logic [TIME_W-1:0] now);
        bit                found;
        logic [TIME_W-1:0] lag;
        step_results.delete();
        found = 1'b0;
        case (req)
            REQ_ADD_REP, REQ_ADD_ONE: begin
                // lowest free slot is claimed
                for (int i = 0; i < NUM_SLOTS && !found; i++) begin
                    if (!slot_occ[i]) begin
                        slot_occ[i] = 1'b1;
                        slot_en[i]  = 1'b1;
                        slot_rep[i] = (req == REQ_ADD_REP);
                        slot_per[i] = per;
                        slot_due[i] = now + per;
                        step_results.push_back(make_result(ST_ADDED, i, 1'b1));
                        found = 1'b1;
                    end
                end
                if (!found)
                    step_results.push_back(make_result(ST_FULL, 0, 1'b1));
            end
            REQ_REMOVE: begin
                if (slot < NUM_SLOTS) begin
                    slot_occ[slot] = 1'b0;
                    slot_en[slot]  = 1'b0;
                end
                step_results.push_back(make_result(ST_ACK, 0, 1'b1));
            end
            REQ_ENABLE: begin
                if (slot < NUM_SLOTS && slot_occ[slot])
                    slot_en[slot] = 1'b1;
                step_results.push_back(make_result(ST_ACK, 0, 1'b1));
            end
            REQ_DISABLE: begin
                if (slot < NUM_SLOTS)
                    slot_en[slot] = 1'b0;
                step_results.push_back(make_result(ST_ACK, 0, 1'b1));
            end
            REQ_RUN: begin
                // wrap-safe due test: sign bit of now - due clear
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    lag = now - slot_due[i];
                    if (slot_occ[i] && slot_en[i] && !lag[TIME_W-1]) begin
                        if (slot_rep[i])
                            slot_due[i] = slot_due[i] + slot_per[i];
                        else
                            slot_en[i] = 1'b0;
                        step_results.push_back(make_result(ST_FIRED, i, 1'b0));
                    end
                end
                if (step_results.size() == 0)
                    step_results.push_back(make_result(ST_NONE, 0, 1'b1));
                else
                    step_results[step_results.size()-1].last = 1'b1;
            end
            default: step_results.push_back(make_result(ST_ACK, 0, 1'b1));
        endcase
    endtask

    // result checking and request capture, both on pre-edge values
    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                got = {o_status, o_slot_out, o_last};
                if (timer_results_q.size() == 0) begin
                    $display("%0t: result with none expected: status=%0d slot=%0d last=%0d",
                             $time, got.status, got.slot, got.last);
                    fail_count++;
                end else begin
                    want = timer_results_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected status=%0d slot=%0d last=%0d, %s",
                                 $time, want.status, want.slot, want.last, "got below");
                        $display("%0t:          actual   status=%0d slot=%0d last=%0d",
                                 $time, got.status, got.slot, got.last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                predict_request(i_req_type, i_slot, i_period, i_now);
                if (row_typed)
                    timer_results_q.push_back(row_expect);
                else
                    foreach (step_results[k])
                        timer_results_q.push_back(step_results[k]);
            end
        end
    end

    // present one request and hold it until taken
    task automatic send_request(input t_stim_row row);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        start      <= 1'b1;
        i_req_type <= row.req;
        i_slot     <= row.slot;
        i_period   <= row.period;
        i_now      <= row.now;
        row_typed  <= row.typed;
        row_expect <= make_result(row.st, int'(row.sl), 1'b1);
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every expected result has come
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (timer_results_q.size() != 0);
        @(posedge i_clk);
    endtask

    function automatic t_stim_row random_request();
        t_stim_row r;
        int        pick;
        int        psel;
        r      = '0;
        r.reps = 5'd1;
        pick   = $urandom_range(99);
        psel   = $urandom_range(99);
        // ticks mostly creep forward, now and then jump anywhere
        if ($urandom_range(99) < 4)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(12);
        r.now    = tick_now;
        r.slot   = ($urandom_range(99) < 85) ? SLOT_IN_W'($urandom_range(NUM_SLOTS-1))
                                             : SLOT_IN_W'($urandom_range(255, NUM_SLOTS));
        r.period = (psel < 8) ? '0 : (psel < 18) ? $urandom : $urandom_range(40, 1);
        if (pick < 18)
            r.req = $urandom_range(1) ? REQ_ADD_REP : REQ_ADD_ONE;
        else if (pick < 32)
            r.req = REQ_REMOVE;
        else if (pick < 44)
            r.req = REQ_ENABLE;
        else if (pick < 52)
            r.req = REQ_DISABLE;
        else if (pick < 96)
            r.req = REQ_RUN;
        else begin
            r.req    = $urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B;
            r.slot   = SLOT_IN_W'($urandom);
            r.period = $urandom;
        end
        return r;
    endfunction

    // directed rows: req, slot, period, now, typed, status, slot, repeats
    localparam t_stim_row DIRECTED_ROWS [23] = '{
        '{REQ_RUN,     8'd0,   32'h0,         32'h0,         1'b1, ST_NONE,  6'd0,  5'd1},
        '{REQ_ENABLE,  8'd0,   32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_DISABLE, 8'd255, 32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_REMOVE,  8'd16,  32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_ADD_REP, 8'd0,   32'h0,         32'h0,         1'b1, ST_ADDED, 6'd0,  5'd1},
        '{REQ_ADD_ONE, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_ADDED, 6'd1,  5'd1},
        '{REQ_RUN,     8'd0,   32'h0,         32'h0,         1'b0, ST_ACK,   6'd0,  5'd1},
        '{REQ_RUN,     8'd0,   32'h0,         32'h7FFF_FFFF, 1'b0, ST_ACK,   6'd0,  5'd1},
        '{REQ_SPARE_A, 8'hAA,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_SPARE_B, 8'h55,  32'hAAAA_AAAA, 32'h5555_5555, 1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_DISABLE, 8'd0,   32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_RUN,     8'd0,   32'h0,         32'h10,        1'b1, ST_NONE,  6'd0,  5'd1},
        '{REQ_REMOVE,  8'd1,   32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_ENABLE,  8'd1,   32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_ADD_REP, 8'd0,   32'h3,         32'h10,        1'b0, ST_ACK,   6'd0,  5'd15},
        '{REQ_ADD_ONE, 8'd0,   32'h1,         32'h10,        1'b1, ST_FULL,  6'd0,  5'd1},
        '{REQ_ENABLE,  8'd0,   32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_RUN,     8'd0,   32'h0,         32'h20,        1'b0, ST_ACK,   6'd0,  5'd1},
        '{REQ_DISABLE, 8'd15,  32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_REMOVE,  8'd15,  32'h0,         32'h0,         1'b1, ST_ACK,   6'd0,  5'd1},
        '{REQ_RUN,     8'd0,   32'h0,         32'hFFFF_FFF0, 1'b0, ST_ACK,   6'd0,  5'd1},
        '{REQ_ADD_ONE, 8'd0,   32'h7FFF_FFFF, 32'hFFFF_FFF0, 1'b1, ST_ADDED, 6'd15, 5'd1},
        '{REQ_RUN,     8'd0,   32'h0,         32'h7FFF_FFEF, 1'b0, ST_ACK,   6'd0,  5'd1}
    };

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        foreach (DIRECTED_ROWS[r])
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_request(DIRECTED_ROWS[r]);

        // random part: sender idles 14 %, then 76 %, then not at all
        tick_now = 32'hFFFF_FF00;
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 76 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2)
                    drain_results();
                send_request(random_request());
            end
        end

        drain_results();
        repeat (NUM_SLOTS + 4) @(posedge i_clk);
        if (fail_count == 0 && timer_results_q.size() == 0) begin
            $display("periodic_task_timer_table_tb: PASS");
        end else begin
            $display("periodic_task_timer_table_tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("%0t: timed out", $time);
        $display("periodic_task_timer_table_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pttt_pkg.sv
rtl/pttt_store.sv
rtl/periodic_task_timer_table.sv
tb/sv/periodic_task_timer_table_tb.sv
